@@ rtl/kmp_pkg.sv @@
// kmp_pkg: shared sizes, types, codes and the memory request bundle of the KMP stream matcher.
// No dependencies; imported by kmp_store, kmp_stream_matcher_top, kmp_props, kmp_checker and tb.
package kmp_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int AW          = $clog2(MAX_PATTERN);
  localparam int LW          = AW + 1;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [LW-1:0]        len_t;
  typedef logic signed [LW-1:0] link_t;
  typedef logic [7:0]           sym_t;

  // failure link meaning "step past this text byte"
  localparam link_t LINK_NONE = '1;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_EVAL,
    ST_BLD_FETCH,
    ST_BLD_STEP,
    ST_BLD_WRITE,
    ST_MATCH
  } state_t;

  typedef struct packed {
    logic  p_we;
    addr_t p_waddr;
    sym_t  p_wdata;
    logic  p_re;
    addr_t p_raddr_a;
    addr_t p_raddr_b;
    logic  f_we;
    addr_t f_waddr;
    link_t f_wdata;
    logic  f_re;
    addr_t f_raddr;
  } kmp_mem_req_t;

endpackage

@@ rtl/kmp_stream_matcher_top.sv @@
// kmp_stream_matcher_top: streaming Knuth-Morris-Pratt matcher, control sequencer and flags.
// Depends on kmp_pkg and kmp_store.
//
// A transaction is taken at a rising edge with start high and busy low. in_action low loads
// one pattern byte (no result); in_last on a pattern byte ends the pattern and starts the
// failure-table build, during which busy stays high: each step of the build is a read of
// the pattern and link memories followed by a compare, either a fall-back along a link or
// an advance that writes a link. in_action high presents a text byte and always gives
// exactly one result on out_match_here / out_found_in_line, marked by a one-cycle out_valid
// strobe; the receiver cannot stall it. A text byte takes a memory read and a compare, plus
// one more read and compare for every failure link it follows; the walk amortises to under
// two reads per byte. Once a line has matched, or while no finished pattern is held, a text
// byte needs no memory read. Bytes beyond the pattern capacity are dropped. in_last on a
// text byte clears the line state after its result.
module kmp_stream_matcher_top import kmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_action,
  input  logic [7:0] in_symbol,
  input  logic in_last,
  output logic out_valid,
  output logic out_match_here,
  output logic out_found_in_line
);

  state_t state_r, state_nxt;

  len_t  len_r, len_nxt;           // finished pattern length, zero while loading
  len_t  load_cnt_r, load_cnt_nxt; // bytes taken in the current load
  len_t  mpos_r, mpos_nxt;         // bytes of pattern matched so far
  logic  line_hit_r, line_hit_nxt;

  addr_t j_r, j_nxt;               // build: position being linked
  link_t k_r, k_nxt;               // build: current border, may be -1
  addr_t pos_r, pos_nxt;           // match walk position
  sym_t  sym_r, sym_nxt;
  logic  last_r, last_nxt;

  logic  out_valid_r, out_valid_nxt;
  logic  out_match_r, out_match_nxt;
  logic  out_found_r, out_found_nxt;

  kmp_mem_req_t req;
  sym_t  p_rd_a;
  sym_t  p_rd_b;
  link_t f_rd;

  logic  accept;
  logic  k_neg;
  addr_t k_addr;
  logic  bld_more;
  logic  bld_adv;
  logic  mt_eq;
  logic  mt_done;
  len_t  mt_npos;
  logic  mt_hit;
  len_t  cnt_inc;
  logic  cnt_room;
  addr_t start_pos;

  kmp_store u_store (
    .clk       (clk),
    .req       (req),
    .p_rdata_a (p_rd_a),
    .p_rdata_b (p_rd_b),
    .f_rdata   (f_rd)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // build control
  assign k_neg    = k_r[LW-1];
  assign k_addr   = k_neg ? '0 : k_r[AW-1:0];
  assign bld_more = ((len_t'(j_r) + len_t'(1)) < len_r);
  assign bld_adv  = k_neg || (p_rd_a == p_rd_b);

  // match walk: hit on the byte, or fallen off the front of the links
  assign mt_eq   = (p_rd_a == sym_r);
  assign mt_done = mt_eq || f_rd[LW-1];
  assign mt_npos = mt_eq ? (len_t'(pos_r) + len_t'(1)) : '0;
  assign mt_hit  = (mt_npos >= len_r);

  assign cnt_room  = (load_cnt_r < len_t'(MAX_PATTERN));
  assign cnt_inc   = cnt_room ? (load_cnt_r + len_t'(1)) : load_cnt_r;
  assign start_pos = (mpos_r >= len_r) ? '0 : mpos_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_PATTERN) begin
            if (in_last) begin
              state_nxt = ST_BLD_EVAL;
            end
          end else if (!line_hit_r && (len_r != '0)) begin
            state_nxt = ST_MATCH;
          end
        end
      end
      ST_BLD_EVAL: begin
        if (!bld_more) begin
          state_nxt = ST_IDLE;
        end else if (bld_adv) begin
          state_nxt = ST_BLD_STEP;
        end else begin
          state_nxt = ST_BLD_FETCH;
        end
      end
      ST_BLD_FETCH: state_nxt = ST_BLD_EVAL;
      ST_BLD_STEP:  state_nxt = ST_BLD_WRITE;
      ST_BLD_WRITE: state_nxt = ST_BLD_EVAL;
      ST_MATCH: begin
        if (mt_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory requests and result
  always_comb begin
    len_nxt       = len_r;
    load_cnt_nxt  = load_cnt_r;
    mpos_nxt      = mpos_r;
    line_hit_nxt  = line_hit_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_match_nxt = out_match_r;
    out_found_nxt = out_found_r;

    req           = '0;
    req.p_waddr   = load_cnt_r[AW-1:0];
    req.p_wdata   = in_symbol;
    req.p_raddr_a = j_r;
    req.p_raddr_b = k_addr;
    req.f_waddr   = j_r;
    req.f_raddr   = k_addr;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_PATTERN) begin
            len_nxt      = '0;
            req.p_we     = cnt_room;
            load_cnt_nxt = cnt_inc;
            if (in_last) begin
              len_nxt      = cnt_inc;
              load_cnt_nxt = '0;
              req.f_we     = 1'b1;
              req.f_waddr  = '0;
              req.f_wdata  = LINK_NONE;
              j_nxt        = '0;
              k_nxt        = LINK_NONE;
              mpos_nxt     = '0;
              line_hit_nxt = 1'b0;
            end
          end else begin
            sym_nxt  = in_symbol;
            last_nxt = in_last;
            if (!line_hit_r && (len_r != '0)) begin
              pos_nxt       = start_pos;
              req.p_re      = 1'b1;
              req.p_raddr_a = start_pos;
              req.f_re      = 1'b1;
              req.f_raddr   = start_pos;
            end else begin
              // nothing to search: flags only
              out_valid_nxt = 1'b1;
              out_match_nxt = 1'b0;
              out_found_nxt = line_hit_r;
              if (in_last) begin
                mpos_nxt     = '0;
                line_hit_nxt = 1'b0;
              end
            end
          end
        end
      end
      ST_BLD_EVAL: begin
        if (bld_more) begin
          if (bld_adv) begin
            j_nxt = j_r + addr_t'(1);
            k_nxt = k_r + link_t'(1);
          end else begin
            k_nxt = f_rd;
          end
        end
      end
      ST_BLD_FETCH, ST_BLD_STEP: begin
        req.p_re = 1'b1;
        req.f_re = 1'b1;
      end
      ST_BLD_WRITE: begin
        // optimised link: skip a border whose next byte would fail the same way
        req.f_we    = 1'b1;
        req.f_wdata = (p_rd_a != p_rd_b) ? k_r : f_rd;
      end
      ST_MATCH: begin
        if (mt_done) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = mt_hit;
          out_found_nxt = mt_hit;
          line_hit_nxt  = mt_hit;
          mpos_nxt      = mt_hit ? '0 : mt_npos;
          if (last_r) begin
            mpos_nxt     = '0;
            line_hit_nxt = 1'b0;
          end
        end else begin
          pos_nxt       = f_rd[AW-1:0];
          req.p_re      = 1'b1;
          req.p_raddr_a = f_rd[AW-1:0];
          req.f_re      = 1'b1;
          req.f_raddr   = f_rd[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      load_cnt_r  <= '0;
      mpos_r      <= '0;
      line_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      load_cnt_r  <= load_cnt_nxt;
      mpos_r      <= mpos_nxt;
      line_hit_r  <= line_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    pos_r       <= pos_nxt;
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    out_match_r <= out_match_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_match_here    = out_match_r;
  assign out_found_in_line = out_found_r;

endmodule

@@ rtl/kmp_store.sv @@
// kmp_store: pattern memory (one write, two read ports) and failure-link memory (one write,
// one read port), both with registered read data. Depends on kmp_pkg.
module kmp_store import kmp_pkg::*; (
  input  logic         clk,
  input  kmp_mem_req_t req,
  output sym_t         p_rdata_a,
  output sym_t         p_rdata_b,
  output link_t        f_rdata
);

  sym_t  pat_mem  [MAX_PATTERN];
  link_t fail_mem [MAX_PATTERN];

  sym_t  p_rd_a_r;
  sym_t  p_rd_b_r;
  link_t f_rd_r;

  always_ff @(posedge clk) begin
    if (req.p_we) begin
      pat_mem[req.p_waddr] <= req.p_wdata;
    end
    if (req.p_re) begin
      p_rd_a_r <= pat_mem[req.p_raddr_a];
      p_rd_b_r <= pat_mem[req.p_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (req.f_we) begin
      fail_mem[req.f_waddr] <= req.f_wdata;
    end
    if (req.f_re) begin
      f_rd_r <= fail_mem[req.f_raddr];
    end
  end

  assign p_rdata_a = p_rd_a_r;
  assign p_rdata_b = p_rd_b_r;
  assign f_rdata   = f_rd_r;

endmodule

@@ rtl/kmp_checker.sv @@
// kmp_props: port-level assertions on the KMP stream matcher, bound to its top level.
// Depends on kmp_pkg and kmp_stream_matcher_top.
module kmp_props import kmp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_action,
  input logic       out_valid,
  input logic       out_match_here,
  input logic       out_found_in_line
);

  logic txn_in;
  assign txn_in = start && !busy;

  // a match always sets the sticky line flag
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_here |-> out_found_in_line)
    else $error("match without line flag");

  // pattern transactions never produce a result
  a_pat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    txn_in && (in_action == ACT_PATTERN) |=> !out_valid)
    else $error("result after pattern byte");

  // a text transaction either strobes next cycle or starts a search
  a_text_progress: assert property (@(posedge clk) disable iff (!rst_n)
    txn_in && (in_action == ACT_TEXT) |=> (out_valid || busy))
    else $error("text byte dropped");

  // results come out only as the block returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("strobe while busy");

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind kmp_stream_matcher_top kmp_props u_kmp_checker (.*);

@@ tb/kmp_checker.sv @@
// kmp_checker: watches both channels of the KMP stream matcher, predicts each text result
// and compares it with what the block returns. Depends on kmp_pkg.
module kmp_checker import kmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_match_here,
  input  logic        out_found_in_line,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_CAP = 20;

  typedef struct packed {
    logic match_here;
    logic found_in_line;
  } flag_pair_t;

  // matcher state as this side sees it
  sym_t  pat_mem  [MAX_PATTERN];
  link_t link_mem [MAX_PATTERN];
  len_t  pat_len;
  len_t  load_cnt;
  len_t  match_pos;
  logic  line_hit;

  flag_pair_t  expected_flags [$];
  int unsigned n_fail;
  int unsigned n_checked;
  int unsigned n_hits;

  initial begin
    n_fail          = 0;
    n_checked       = 0;
    n_hits          = 0;
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    hits_seen       = 0;
  end

  // optimised failure links: -1 means step past the text byte
  function automatic void build_links(len_t len);
    int j;
    int k;
    j = 0;
    k = -1;
    link_mem[0] = LINK_NONE;
    while (j + 1 < int'(len)) begin
      if (k < 0 || pat_mem[j] == pat_mem[k]) begin
        j++;
        k++;
        link_mem[j] = (pat_mem[j] != pat_mem[k]) ? link_t'(k) : link_mem[k];
      end else begin
        k = int'(link_mem[k]);
      end
    end
  endfunction

  function automatic void take_pattern_byte(sym_t s, logic lst);
    pat_len = '0;
    if (load_cnt < MAX_PATTERN) begin
      pat_mem[load_cnt[AW-1:0]] = s;
      load_cnt++;
    end
    if (lst) begin
      pat_len   = load_cnt;
      load_cnt  = '0;
      build_links(pat_len);
      match_pos = '0;
      line_hit  = 1'b0;
    end
  endfunction

  function automatic flag_pair_t scan_text_byte(sym_t s, logic lst);
    flag_pair_t f;
    int pos;
    f.match_here = 1'b0;
    if (!line_hit && pat_len != 0) begin
      pos = (match_pos >= pat_len) ? 0 : int'(match_pos);
      while (pos >= 0 && pat_mem[pos] != s) pos = int'(link_mem[pos]);
      pos++;
      if (pos >= int'(pat_len)) begin
        f.match_here = 1'b1;
        line_hit     = 1'b1;
        pos          = 0;
      end
      match_pos = len_t'(pos);
    end
    f.found_in_line = line_hit;
    if (lst) begin
      match_pos = '0;
      line_hit  = 1'b0;
    end
    return f;
  endfunction

  function automatic void flag_mismatch(string field, logic exp_v, logic act_v);
    n_fail++;
    if (n_fail <= REPORT_CAP)
      $display("%0t ns: ERROR %s expected %0b actual %0b", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    flag_pair_t exp_f;
    if (!rst_n) begin
      pat_len   = '0;
      load_cnt  = '0;
      match_pos = '0;
      line_hit  = 1'b0;
      expected_flags.delete();
    end else begin
      // results first: a result never belongs to a transaction taken at the same edge
      if (out_valid === 1'b1) begin
        if (expected_flags.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_CAP)
            $display("%0t ns: ERROR unexpected result, expected none actual %0b/%0b",
                     $time, out_match_here, out_found_in_line);
        end else begin
          exp_f = expected_flags.pop_front();
          n_checked++;
          if (out_match_here === 1'b1) n_hits++;
          if (out_match_here !== exp_f.match_here)
            flag_mismatch("match_here", exp_f.match_here, out_match_here);
          if (out_found_in_line !== exp_f.found_in_line)
            flag_mismatch("found_in_line", exp_f.found_in_line, out_found_in_line);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_action == ACT_PATTERN) take_pattern_byte(in_symbol, in_last);
        else expected_flags.push_back(scan_text_byte(in_symbol, in_last));
      end
    end
    fail_count      <= n_fail;
    outstanding     <= expected_flags.size();
    results_checked <= n_checked;
    hits_seen       <= n_hits;
  end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for kmp_stream_matcher_top; kmp_checker does all prediction.
// Depends on kmp_pkg, kmp_stream_matcher_top and kmp_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmp_pkg::*;

  // random part stops after this many transactions in total
  localparam int unsigned ITEMS          = 1050;
  // longest legal quiet stretch is a full link build plus a text byte's walk; the
  // watchdog sits well beyond that
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  // after the last result a trailing pattern may still be building its links
  localparam int unsigned DRAIN_CYCLES   = 1300;
  // longest pattern that random lines embed whole
  localparam int unsigned EMBED_MAX      = 24;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic start     = 1'b0;
  logic in_action = ACT_PATTERN;
  sym_t in_symbol = '0;
  logic in_last   = 1'b0;
  logic busy;
  logic out_valid;
  logic out_match_here;
  logic out_found_in_line;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned hits_seen;

  // stimulus bookkeeping
  int unsigned items_sent      = 0;
  int unsigned patterns_loaded = 0;
  int unsigned burst_left      = 0;
  int unsigned quiet_cycles    = 0;
  sym_t        alpha [3];
  int unsigned alpha_n = 1;
  sym_t        pat_q [$];

  always #1 clk = ~clk;

  kmp_stream_matcher_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_match_here   (out_match_here),
    .out_found_in_line(out_found_in_line)
  );

  kmp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_match_here   (out_match_here),
    .out_found_in_line(out_found_in_line),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .hits_seen        (hits_seen)
  );

  // Watchdog: any accepted transaction or result strobe counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // One transaction. The sender runs in bursts; between bursts start drops and the fields
  // carry junk the block must ignore. Bursts are sometimes long, giving stretches of
  // back-to-back transactions. Each signal gets one assignment per edge: start stays high
  // across consecutive transactions of a burst.
  task automatic send_item(logic act, sym_t s, logic lst);
    if (burst_left == 0) begin
      start     <= 1'b0;
      in_action <= logic'($urandom_range(0, 1));
      in_symbol <= sym_t'($urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    start     <= 1'b1;
    in_action <= act;
    in_symbol <= s;
    in_last   <= lst;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    burst_left--;
    items_sent++;
    if (act == ACT_PATTERN && lst) patterns_loaded++;
  endtask

  // Fresh symbol set; a small set makes patterns overlap themselves so that the
  // failure links get a real workout.
  task automatic new_alphabet(int unsigned n);
    alpha_n = n;
    foreach (alpha[i]) alpha[i] = sym_t'($urandom_range(0, 255));
  endtask

  // Mostly in-alphabet bytes, with the odd full-range byte as noise.
  function automatic sym_t text_byte();
    if ($urandom_range(0, 7) == 0) return sym_t'($urandom_range(0, 255));
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  // Load a pattern; with 'interleave' set, text bytes slip in while the load is
  // under way, when no finished pattern is held.
  task automatic load_pattern(int unsigned len, bit interleave);
    sym_t s;
    pat_q.delete();
    for (int unsigned i = 0; i < len; i++) begin
      s = alpha[$urandom_range(0, alpha_n - 1)];
      pat_q.push_back(s);
      send_item(ACT_PATTERN, s, i == len - 1);
      if (interleave && i != len - 1 && $urandom_range(0, 2) == 0)
        send_item(ACT_TEXT, text_byte(), $urandom_range(0, 3) == 0);
    end
  endtask

  // A text line; 'closed' puts last on its final byte, otherwise the line runs on.
  task automatic send_line(sym_t bytes [$], bit closed);
    foreach (bytes[i]) send_item(ACT_TEXT, bytes[i], closed && i == bytes.size() - 1);
  endtask

  initial begin
    sym_t line_q [$];
    bit   long_done;
    long_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // no pattern held yet: text never matches
    send_item(ACT_TEXT, 8'h00, 1'b0);
    send_item(ACT_TEXT, 8'hFF, 1'b1);
    // single-byte pattern at the top of the byte range
    send_item(ACT_PATTERN, 8'hFF, 1'b1);
    send_item(ACT_TEXT, 8'h00, 1'b0);
    send_item(ACT_TEXT, 8'hFF, 1'b0);     // match
    send_item(ACT_TEXT, 8'hFF, 1'b0);     // line already hit: ignored, flag sticks
    send_item(ACT_TEXT, 8'h00, 1'b1);     // end of line clears the flag
    send_item(ACT_TEXT, 8'hFF, 1'b1);     // match on the closing byte
    // self-overlapping pattern: a partial match falls back along a link
    send_item(ACT_PATTERN, 8'h00, 1'b0);
    send_item(ACT_PATTERN, 8'h00, 1'b0);
    send_item(ACT_PATTERN, 8'h01, 1'b1);
    send_item(ACT_TEXT, 8'h00, 1'b0);
    send_item(ACT_TEXT, 8'h00, 1'b0);
    send_item(ACT_TEXT, 8'h00, 1'b0);
    send_item(ACT_TEXT, 8'h01, 1'b0);     // match after the fall-back
    // load starts mid-line: no pattern held, sticky flag carries on until finished
    send_item(ACT_PATTERN, 8'h80, 1'b0);
    send_item(ACT_TEXT, 8'h80, 1'b0);
    send_item(ACT_PATTERN, 8'h7F, 1'b1);  // finishing the pattern clears line state
    send_item(ACT_TEXT, 8'h80, 1'b0);
    send_item(ACT_TEXT, 8'h7F, 1'b1);     // match
    pat_q = '{8'h80, 8'h7F};
    alpha[0] = 8'h80;
    alpha[1] = 8'h7F;
    alpha[2] = 8'h00;
    alpha_n  = 2;

    // ---- random part ----
    while (items_sent < ITEMS) begin
      if (!long_done && items_sent >= 350) begin
        // overlong pattern of one repeated byte: only the first MAX_PATTERN bytes are
        // kept, so a line of exactly MAX_PATTERN copies matches on its final byte
        long_done = 1'b1;
        new_alphabet(1);
        load_pattern(MAX_PATTERN + 2, 1'b0);
        line_q.delete();
        repeat (MAX_PATTERN) line_q.push_back(alpha[0]);
        send_line(line_q, 1'b1);
        new_alphabet(2);
        load_pattern($urandom_range(1, 6), 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            // noise: full-range text bytes, last at random
            repeat ($urandom_range(1, 4))
              send_item(ACT_TEXT, sym_t'($urandom_range(0, 255)),
                        logic'($urandom_range(0, 1)));
          end
          1, 2: begin
            new_alphabet($urandom_range(1, 3));
            load_pattern(($urandom_range(0, 4) == 0) ? $urandom_range(7, 20)
                                                     : $urandom_range(1, 6),
                         $urandom_range(0, 3) == 0);
          end
          default: begin
            // line with the pattern usually embedded, sometimes twice; the odd line
            // is left open and runs into whatever follows
            line_q.delete();
            repeat ($urandom_range(0, 8)) line_q.push_back(text_byte());
            if (pat_q.size() <= EMBED_MAX && $urandom_range(0, 2) != 0) begin
              foreach (pat_q[i]) line_q.push_back(pat_q[i]);
              if ($urandom_range(0, 3) == 0)
                foreach (pat_q[i]) line_q.push_back(pat_q[i]);
            end
            repeat ($urandom_range(0, 8)) line_q.push_back(text_byte());
            if (line_q.size() == 0) line_q.push_back(text_byte());
            send_line(line_q, $urandom_range(0, 7) != 0);
          end
        endcase
      end
    end

    // ---- drain ----
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions with %0d finished patterns, one past capacity.",
             items_sent, patterns_loaded);
    $display("Checked %0d text results, %0d of them with a match.",
             results_checked, hits_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/kmp_pkg.sv
rtl/kmp_store.sv
rtl/kmp_stream_matcher_top.sv
rtl/kmp_checker.sv
tb/kmp_checker.sv
tb/tb.sv
